// ----- design/tsm_pkg.sv -----
// tsm_pkg: shared types and constants of the tlb shootdown slot mailbox
// used by every module of the block but tsm_ram; depends on nothing

package tsm_pkg;

   localparam int ASID_W   = 16;
   localparam int ADDR_W   = 48;
   localparam int PAGES_W  = 42;
   localparam int SLOTS_W  = 7;
   localparam int KIND_W   = 3;

   localparam logic [PAGES_W-1:0] PAGES_MAX       = {PAGES_W{1'b1}};
   localparam logic [PAGES_W-1:0] THRESHOLD_RESET = 42'd32;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [0:0] {
      CMD_DEPOSIT = 1'b0,
      CMD_DRAIN   = 1'b1
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK   = 3'd0,
      KIND_RANGE = 3'd1,
      KIND_WHOLE = 3'd2,
      KIND_ALL   = 3'd3,
      KIND_IDLE  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_READ,
      BACK_EMIT
   } back_state_type;

   // classified item as it travels from front to back
   typedef struct packed {
      cmd_type            cmd;
      logic               whole;
      logic [ASID_W-1:0]  asid;
      logic [ADDR_W-1:0]  base;
      logic [ADDR_W-1:0]  length;
      logic [ADDR_W-1:0]  pages;
   } entry_type;

endpackage

// ----- design/tsm_ram.sv -----
// tsm_ram: generic single write port, single read port ram with registered read
// no dependencies

module tsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/tsm_front.sv -----
// tsm_front: accepts request items, classifies and masks them, and queues them
// depends on tsm_pkg

module tsm_front #(
   parameter int PAGE_SHIFT = 12,
   parameter int ADDR_BITS  = 48,
   parameter int ASID_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic                       req_whole_space,
   input  logic [tsm_pkg::ASID_W-1:0] req_asid,
   input  logic [tsm_pkg::ADDR_W-1:0] req_base_addr,
   input  logic [tsm_pkg::ADDR_W-1:0] req_length_bytes,
   output logic                       q_valid,
   input  logic                       q_pop,
   output tsm_pkg::entry_type         q_entry
);
   import tsm_pkg::*;

   localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   entry_type      entries_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]  fill_ff, fill_in;
   entry_type      classified;
   logic           push;
   logic [AW-1:0]  len_masked;

   always_comb begin
      len_masked           = req_length_bytes[AW-1:0];
      classified.cmd       = cmd_type'(req_cmd);
      classified.whole     = req_whole_space;
      classified.asid      = ASID_W'(req_asid[ASID_BITS-1:0]);
      // a whole space deposit keeps no range and adds no pages
      if (req_whole_space) begin
         classified.base   = '0;
         classified.length = '0;
         classified.pages  = '0;
      end else begin
         classified.base   = ADDR_W'(req_base_addr[AW-1:0]);
         classified.length = ADDR_W'(len_masked);
         classified.pages  = ADDR_W'(len_masked >> PAGE_SHIFT);
      end
   end

   assign req_ready = (fill_ff != FW'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != '0);
   assign q_entry   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = PW'(wr_ptr_ff + 1'b1);
      end
      if (q_pop) begin
         rd_ptr_in = PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !q_pop) begin
         fill_in = FW'(fill_ff + 1'b1);
      end else if (q_pop && !push) begin
         fill_in = FW'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ----- design/tsm_back.sv -----
// tsm_back: carries out deposits and drains, owns the slot ram and the result register
// depends on tsm_pkg and tsm_ram

module tsm_back #(
   parameter int SLOT_COUNT = 64,
   parameter int PAGE_SHIFT = 12,
   parameter int ADDR_BITS  = 48,
   parameter int ASID_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [tsm_pkg::PAGES_W-1:0]  csr_wr_data,
   input  logic                         q_valid,
   output logic                         q_pop,
   input  tsm_pkg::entry_type           q_entry,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tsm_pkg::KIND_W-1:0]   rsp_kind,
   output logic [tsm_pkg::ASID_W-1:0]   rsp_flush_asid,
   output logic [tsm_pkg::ADDR_W-1:0]   rsp_flush_base,
   output logic [tsm_pkg::ADDR_W-1:0]   rsp_flush_length,
   output logic                         rsp_overflowed,
   output logic [tsm_pkg::SLOTS_W-1:0]  rsp_drained_slots,
   output logic [tsm_pkg::PAGES_W-1:0]  rsp_drained_pages,
   output logic                         rsp_last
);
   import tsm_pkg::*;

   localparam int AW    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int CW    = $clog2(SLOT_COUNT + 1);
   localparam int IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SUM_W = AW - PAGE_SHIFT + CW;
   localparam int CMPW  = (SUM_W > PAGES_W) ? SUM_W : PAGES_W;
   localparam int RW    = 1 + ASID_BITS + 2 * AW;

   back_state_type      state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                pending_ff, pending_in;
   logic                flag_ff, flag_in;
   logic [PAGES_W-1:0]  thr_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff;
   logic [ASID_W-1:0]   asid_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [ADDR_W-1:0]   len_ff;
   logic                ovf_ff;
   logic [SLOTS_W-1:0]  slots_ff;
   logic [PAGES_W-1:0]  pages_ff;
   logic                last_ff;

   // result being formed this cycle
   logic                emit;
   kind_type            res_kind;
   logic [ASID_W-1:0]   res_asid;
   logic [ADDR_W-1:0]   res_base;
   logic [ADDR_W-1:0]   res_len;
   logic                res_ovf;
   logic [SLOTS_W-1:0]  res_slots;
   logic [PAGES_W-1:0]  res_pages;
   logic                res_last;

   logic                out_free;
   logic [CMPW-1:0]     sum_wide;
   logic                over_threshold;
   logic [PAGES_W-1:0]  pages_sat;

   logic                ram_we, ram_re;
   logic [IW-1:0]       ram_raddr;
   logic [RW-1:0]       ram_wdata, ram_rdata;
   logic                rd_whole;
   logic [ASID_BITS-1:0] rd_asid;
   logic [AW-1:0]       rd_base, rd_len;

   tsm_ram #(
      .WIDTH (RW),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ram_wdata = {q_entry.whole, q_entry.asid[ASID_BITS-1:0],
                       q_entry.base[AW-1:0], q_entry.length[AW-1:0]};
   assign rd_len    = ram_rdata[AW-1:0];
   assign rd_base   = ram_rdata[2*AW-1:AW];
   assign rd_asid   = ram_rdata[2*AW+ASID_BITS-1:2*AW];
   assign rd_whole  = ram_rdata[RW-1];

   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign sum_wide       = CMPW'(sum_ff);
   assign over_threshold = sum_wide > CMPW'(thr_ff);
   assign pages_sat      = (sum_wide > CMPW'(PAGES_MAX)) ? PAGES_MAX
                                                         : sum_wide[PAGES_W-1:0];

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      idx_in     = idx_ff;
      pending_in = pending_ff;
      flag_in    = flag_ff;
      q_pop      = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_raddr  = idx_ff;
      emit       = 1'b0;
      res_kind   = KIND_IDLE;
      res_asid   = '0;
      res_base   = '0;
      res_len    = '0;
      res_ovf    = 1'b0;
      res_slots  = '0;
      res_pages  = '0;
      res_last   = 1'b0;

      case (state_ff)
         BACK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop    = 1'b1;
               emit     = 1'b1;
               res_last = 1'b1;
               if (q_entry.cmd == CMD_DEPOSIT) begin
                  res_kind   = KIND_ACK;
                  pending_in = 1'b1;
                  if (count_ff < CW'(SLOT_COUNT)) begin
                     ram_we   = 1'b1;
                     count_in = CW'(count_ff + 1'b1);
                     sum_in   = SUM_W'(sum_ff + SUM_W'(q_entry.pages));
                  end else begin
                     flag_in = 1'b1;
                     res_ovf = 1'b1;
                  end
               end else if (pending_ff) begin
                  pending_in = 1'b0;
                  flag_in    = 1'b0;
                  res_slots  = SLOTS_W'(count_ff);
                  res_pages  = pages_sat;
                  if (flag_ff || over_threshold) begin
                     res_kind = KIND_ALL;
                     count_in = '0;
                     sum_in   = '0;
                  end else if (count_ff == '0) begin
                     res_kind = KIND_IDLE;
                  end else begin
                     // walk the occupied slots, results come from the ram
                     emit     = 1'b0;
                     idx_in   = '0;
                     state_in = BACK_READ;
                  end
               end else begin
                  res_kind = KIND_IDLE;
               end
            end
         end
         BACK_READ: begin
            ram_re   = 1'b1;
            state_in = BACK_EMIT;
         end
         BACK_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               res_asid = ASID_W'(rd_asid);
               if (rd_whole) begin
                  res_kind = KIND_WHOLE;
               end else begin
                  res_kind = KIND_RANGE;
                  res_base = ADDR_W'(rd_base);
                  res_len  = ADDR_W'(rd_len);
               end
               if (CW'(CW'(idx_ff) + 1'b1) == count_ff) begin
                  res_last  = 1'b1;
                  res_slots = SLOTS_W'(count_ff);
                  res_pages = pages_sat;
                  count_in  = '0;
                  sum_in    = '0;
                  state_in  = BACK_IDLE;
               end else begin
                  idx_in   = IW'(idx_ff + 1'b1);
                  state_in = BACK_READ;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         idx_ff       <= '0;
         pending_ff   <= 1'b0;
         flag_ff      <= 1'b0;
         thr_ff       <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         pending_ff   <= pending_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= res_kind;
         asid_ff  <= res_asid;
         base_ff  <= res_base;
         len_ff   <= res_len;
         ovf_ff   <= res_ovf;
         slots_ff <= res_slots;
         pages_ff <= res_pages;
         last_ff  <= res_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_flush_asid    = asid_ff;
   assign rsp_flush_base    = base_ff;
   assign rsp_flush_length  = len_ff;
   assign rsp_overflowed    = ovf_ff;
   assign rsp_drained_slots = slots_ff;
   assign rsp_drained_pages = pages_ff;
   assign rsp_last          = last_ff;

endmodule

// ----- design/tlb_shootdown_slot_mailbox_unit.sv -----
// tlb_shootdown_slot_mailbox_unit: top level of the per-cpu tlb shootdown mailbox
// depends on tsm_pkg, tsm_front, tsm_back (and tsm_ram through tsm_back)
//
//   port group  dir   handshake         carries
//   req_*       in    valid / ready     one deposit or drain item
//   rsp_*       out   valid / ready     ack, flush, flush-all or idle item, last marks the end
//   csr_*       in    write enable      flush threshold in pages, no wait
//
// a queued item reaches the back unit from the front queue registers; a deposit, an idle
// drain or a flush-all drain is finished there in the idle state. a drain that walks the
// slots passes a read state and an emit state per occupied slot, for the registered ram read.
// reset clears control and fill count and reloads the threshold; the slot ram is never
// cleared, the fill count marks which slots hold data. a stalled result holds the back
// unit, while the two-entry front queue keeps taking items until it is full.

module tlb_shootdown_slot_mailbox_unit #(
   parameter int SLOT_COUNT = 64,
   parameter int PAGE_SHIFT = 12,
   parameter int ADDR_BITS  = 48,
   parameter int ASID_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic                         req_whole_space,
   input  logic [tsm_pkg::ASID_W-1:0]   req_asid,
   input  logic [tsm_pkg::ADDR_W-1:0]   req_base_addr,
   input  logic [tsm_pkg::ADDR_W-1:0]   req_length_bytes,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tsm_pkg::KIND_W-1:0]   rsp_kind,
   output logic [tsm_pkg::ASID_W-1:0]   rsp_flush_asid,
   output logic [tsm_pkg::ADDR_W-1:0]   rsp_flush_base,
   output logic [tsm_pkg::ADDR_W-1:0]   rsp_flush_length,
   output logic                         rsp_overflowed,
   output logic [tsm_pkg::SLOTS_W-1:0]  rsp_drained_slots,
   output logic [tsm_pkg::PAGES_W-1:0]  rsp_drained_pages,
   output logic                         rsp_last,
   input  logic                         csr_wr_en,
   input  logic [tsm_pkg::PAGES_W-1:0]  csr_wr_data
);
   import tsm_pkg::*;

   logic       q_valid;
   logic       q_pop;
   entry_type  q_entry;

   tsm_front #(
      .PAGE_SHIFT (PAGE_SHIFT),
      .ADDR_BITS  (ADDR_BITS),
      .ASID_BITS  (ASID_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_whole_space  (req_whole_space),
      .req_asid         (req_asid),
      .req_base_addr    (req_base_addr),
      .req_length_bytes (req_length_bytes),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_entry          (q_entry)
   );

   tsm_back #(
      .SLOT_COUNT (SLOT_COUNT),
      .PAGE_SHIFT (PAGE_SHIFT),
      .ADDR_BITS  (ADDR_BITS),
      .ASID_BITS  (ASID_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_entry           (q_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_flush_asid    (rsp_flush_asid),
      .rsp_flush_base    (rsp_flush_base),
      .rsp_flush_length  (rsp_flush_length),
      .rsp_overflowed    (rsp_overflowed),
      .rsp_drained_slots (rsp_drained_slots),
      .rsp_drained_pages (rsp_drained_pages),
      .rsp_last          (rsp_last)
   );

endmodule

// ----- dv/tb_tlb_shootdown_slot_mailbox_unit.sv -----
`timescale 1ns / 1ps
// tb_tlb_shootdown_slot_mailbox_unit: self-checking testbench of the tlb shootdown mailbox
// depends on tsm_pkg and tlb_shootdown_slot_mailbox_unit; mirrors the slots to predict results

module tb_tlb_shootdown_slot_mailbox_unit;
   import tsm_pkg::*;

   localparam int SLOT_TOTAL     = 64;
   localparam int PAGE_SHIFT_TB  = 12;
   localparam int IDLE_PCT       = 38;
   localparam int HOLD_CYCLES    = 300;
   // longest legal silence is the receiver hold, so this leaves a wide margin
   localparam int QUIET_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int RANDOM_ITEMS   = 32;

   typedef struct packed {
      kind_type            kind;
      logic [ASID_W-1:0]   asid;
      logic [ADDR_W-1:0]   base;
      logic [ADDR_W-1:0]   length;
      logic                ovf;
      logic [SLOTS_W-1:0]  slots;
      logic [PAGES_W-1:0]  pages;
      logic                last;
   } rsp_note_type;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic                  req_cmd          = 1'b0;
   logic                  req_whole_space  = 1'b0;
   logic [ASID_W-1:0]     req_asid         = '0;
   logic [ADDR_W-1:0]     req_base_addr    = '0;
   logic [ADDR_W-1:0]     req_length_bytes = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [ASID_W-1:0]     rsp_flush_asid;
   logic [ADDR_W-1:0]     rsp_flush_base;
   logic [ADDR_W-1:0]     rsp_flush_length;
   logic                  rsp_overflowed;
   logic [SLOTS_W-1:0]    rsp_drained_slots;
   logic [PAGES_W-1:0]    rsp_drained_pages;
   logic                  rsp_last;
   logic                  csr_wr_en        = 1'b0;
   logic [PAGES_W-1:0]    csr_wr_data      = '0;

   // mirror of the mailbox state
   bit                    mb_busy  [SLOT_TOTAL];
   bit                    mb_whole [SLOT_TOTAL];
   logic [ASID_W-1:0]     mb_asid  [SLOT_TOTAL];
   logic [ADDR_W-1:0]     mb_base  [SLOT_TOTAL];
   logic [ADDR_W-1:0]     mb_len   [SLOT_TOTAL];
   bit                    mb_pending;
   bit                    mb_flush_all;
   logic [PAGES_W-1:0]    mb_threshold = THRESHOLD_RESET;

   rsp_note_type          awaited_rsp[$];

   bit                    sender_steady;
   bit                    ready_steady;
   int                    hold_request;
   int                    hold_left;
   int                    quiet_cycles;
   int                    errors;
   int                    items_sent;
   int                    results_seen;
   int                    overflow_acks;
   int                    flush_all_drains;
   int                    slot_flushes;
   int                    idle_drains;

   tlb_shootdown_slot_mailbox_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_whole_space   (req_whole_space),
      .req_asid          (req_asid),
      .req_base_addr     (req_base_addr),
      .req_length_bytes  (req_length_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_flush_asid    (rsp_flush_asid),
      .rsp_flush_base    (rsp_flush_base),
      .rsp_flush_length  (rsp_flush_length),
      .rsp_overflowed    (rsp_overflowed),
      .rsp_drained_slots (rsp_drained_slots),
      .rsp_drained_pages (rsp_drained_pages),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [ADDR_W-1:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[ADDR_W-1:0];
   endfunction

   // counts and page sum go on the final result of a drain
   function automatic rsp_note_type close_drain(input rsp_note_type note, input int occupied,
                                                input logic [63:0] pages_sum);
      rsp_note_type closed;
      closed       = note;
      closed.slots = SLOTS_W'(occupied);
      closed.pages = (pages_sum > PAGES_MAX) ? PAGES_MAX : pages_sum[PAGES_W-1:0];
      closed.last  = 1'b1;
      return closed;
   endfunction

   task automatic mirror_mailbox(input cmd_type cmd, input logic whole,
                                 input logic [ASID_W-1:0] asid,
                                 input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] len);
      rsp_note_type  note;
      logic [63:0]   pages_sum;
      int            free_slot;
      int            occupied;
      int            emitted;
      bit            flush_all;
      note      = '0;
      pages_sum = '0;
      free_slot = -1;
      occupied  = 0;
      emitted   = 0;
      if (cmd == CMD_DEPOSIT) begin
         for (int i = 0; i < SLOT_TOTAL; i++)
            if (free_slot < 0 && !mb_busy[i]) free_slot = i;
         if (free_slot >= 0) begin
            mb_busy[free_slot]  = 1'b1;
            mb_whole[free_slot] = whole;
            mb_asid[free_slot]  = asid;
            mb_base[free_slot]  = whole ? '0 : base;
            mb_len[free_slot]   = whole ? '0 : len;
         end else begin
            mb_flush_all = 1'b1;
            overflow_acks++;
         end
         mb_pending = 1'b1;
         note.kind  = KIND_ACK;
         note.ovf   = (free_slot < 0);
         note.last  = 1'b1;
         awaited_rsp.push_back(note);
      end else if (!mb_pending) begin
         note.kind = KIND_IDLE;
         note.last = 1'b1;
         idle_drains++;
         awaited_rsp.push_back(note);
      end else begin
         for (int i = 0; i < SLOT_TOTAL; i++) begin
            if (mb_busy[i]) begin
               occupied++;
               if (!mb_whole[i]) pages_sum = pages_sum + (mb_len[i] >> PAGE_SHIFT_TB);
            end
         end
         flush_all    = mb_flush_all || (pages_sum > mb_threshold);
         mb_pending   = 1'b0;
         mb_flush_all = 1'b0;
         if (flush_all) begin
            note.kind = KIND_ALL;
            flush_all_drains++;
            awaited_rsp.push_back(close_drain(note, occupied, pages_sum));
         end else if (occupied == 0) begin
            note.kind = KIND_IDLE;
            idle_drains++;
            awaited_rsp.push_back(close_drain(note, occupied, pages_sum));
         end else begin
            for (int i = 0; i < SLOT_TOTAL; i++) begin
               if (mb_busy[i]) begin
                  note      = '0;
                  note.asid = mb_asid[i];
                  if (mb_whole[i]) begin
                     note.kind = KIND_WHOLE;
                  end else begin
                     note.kind   = KIND_RANGE;
                     note.base   = mb_base[i];
                     note.length = mb_len[i];
                  end
                  emitted++;
                  slot_flushes++;
                  if (emitted == occupied) note = close_drain(note, occupied, pages_sum);
                  awaited_rsp.push_back(note);
               end
            end
         end
         for (int i = 0; i < SLOT_TOTAL; i++) mb_busy[i] = 1'b0;
      end
   endtask

   // entered and left at a falling edge
   task automatic send_item(input cmd_type cmd, input logic whole,
                            input logic [ASID_W-1:0] asid,
                            input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] len);
      while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_whole_space  <= whole;
      req_asid         <= asid;
      req_base_addr    <= base;
      req_length_bytes <= len;
      do @(posedge clock); while (!req_ready);
      mirror_mailbox(cmd, whole, asid, base, len);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic deposit(input logic whole, input logic [ASID_W-1:0] asid,
                          input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] len);
      send_item(CMD_DEPOSIT, whole, asid, base, len);
   endtask

   task automatic drain();
      send_item(CMD_DRAIN, 1'($urandom_range(1)), ASID_W'($urandom_range(16'hFFFF)),
                rand48(), rand48());
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [PAGES_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      mb_threshold = value;
   endtask

   // mostly a few pages so that page sums land near small thresholds
   function automatic logic [ADDR_W-1:0] rand_length();
      logic [ADDR_W-1:0] len;
      logic [ADDR_W-1:0] pages;
      len   = rand48();
      pages = ADDR_W'($urandom_range(12));
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: len = (pages << PAGE_SHIFT_TB) | (len & 48'hFFF);
         6, 7:             len = len;
         8:                len = {ADDR_W{1'b1}};
         default:          len = len & 48'hFFF;
      endcase
      return len;
   endfunction

   function automatic logic [PAGES_W-1:0] pick_threshold();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(5))
         0:       return '0;
         1:       return PAGES_MAX;
         2:       return THRESHOLD_RESET;
         3:       return r[PAGES_W-1:0];
         default: return r[PAGES_W-1:0] & 42'h3F;
      endcase
   endfunction

   task automatic random_deposit();
      deposit($urandom_range(3) == 0, ASID_W'($urandom_range(16'hFFFF)), rand48(),
              rand_length());
   endtask

   // field extremes, whole-space deposits, exact threshold edge, idle drains
   task automatic test_directed();
      drain();
      deposit(1'b0, 16'h0000, 48'h0, 48'h0);
      deposit(1'b1, 16'hFFFF, {ADDR_W{1'b1}}, {ADDR_W{1'b1}});
      deposit(1'b0, 16'h5A5A, 48'h0000_DEAD_B000, 48'hFFF);
      drain();
      drain();
      deposit(1'b0, 16'h0001, 48'h0000_1000_0000, 48'd32 << PAGE_SHIFT_TB);
      drain();
      deposit(1'b0, 16'h00A5, 48'h7FFF_FFFF_F000, 48'd20 << PAGE_SHIFT_TB);
      deposit(1'b0, 16'hA500, 48'h8000_0000_0000, (48'd13 << PAGE_SHIFT_TB) | 48'hFFF);
      drain();
      deposit(1'b0, 16'hFFFF, {ADDR_W{1'b1}}, {ADDR_W{1'b1}});
      drain();
      deposit(1'b1, 16'h0007, 48'h0, 48'h0);
      drain();
   endtask

   task automatic test_threshold_extremes();
      write_threshold('0);
      deposit(1'b0, 16'h0101, rand48(), 48'hFFF);
      deposit(1'b1, 16'h0202, rand48(), rand48());
      drain();
      deposit(1'b0, 16'h0303, rand48(), 48'h1000);
      drain();
      // every slot full of maximal ranges still stays under the largest threshold
      write_threshold(PAGES_MAX);
      repeat (SLOT_TOTAL)
         deposit($urandom_range(7) == 0, ASID_W'($urandom_range(16'hFFFF)), rand48(),
                 {ADDR_W{1'b1}});
      drain();
   endtask

   task automatic test_overflow();
      repeat (SLOT_TOTAL + 3) random_deposit();
      drain();
      random_deposit();
      drain();
   endtask

   task automatic test_backpressure();
      sender_steady = 1'b1;
      hold_request  = HOLD_CYCLES;
      repeat (12) random_deposit();
      drain();
      drain();
      sender_steady = 1'b0;
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int sent_here;
      int burst;
      sent_here = 0;
      while (sent_here < RANDOM_ITEMS) begin
         sender_steady = (sent_here >= 4 && sent_here < 28);
         ready_steady  = sender_steady;
         if ($urandom_range(3) == 0) write_threshold(pick_threshold());
         if ($urandom_range(7) == 0) begin
            drain();
            sent_here++;
         end
         burst = ($urandom_range(9) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 8);
         if (burst > RANDOM_ITEMS - sent_here) burst = RANDOM_ITEMS - sent_here;
         repeat (burst) begin
            random_deposit();
            sent_here++;
         end
         drain();
         sent_here++;
      end
      sender_steady = 1'b0;
      ready_steady  = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_threshold_extremes();
      test_overflow();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      repeat (20) @(negedge clock);
      if (awaited_rsp.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaited_rsp.size());
         errors++;
      end
      $display("covered %0d items and %0d results: %0d overflowed deposits, %0d flush-all drains,",
               items_sent, results_seen, overflow_acks, flush_all_drains);
      $display("%0d per-slot flushes and %0d idle drains, thresholds from zero to full scale",
               slot_flushes, idle_drains);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // receiver: random stalls, steady stretches, and one long hold
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (ready_steady) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : rsp_checker
      rsp_note_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected result, kind %0d", $time, rsp_kind);
            errors++;
         end else begin
            want = awaited_rsp.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_kind));
            check_field("flush_asid", 64'(want.asid), 64'(rsp_flush_asid));
            check_field("flush_base", 64'(want.base), 64'(rsp_flush_base));
            check_field("flush_length", 64'(want.length), 64'(rsp_flush_length));
            check_field("overflowed", 64'(want.ovf), 64'(rsp_overflowed));
            check_field("drained_slots", 64'(want.slots), 64'(rsp_drained_slots));
            check_field("drained_pages", 64'(want.pages), 64'(rsp_drained_pages));
            check_field("last", 64'(want.last), 64'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule

// ----- filelist.f -----
design/tsm_pkg.sv
design/tsm_ram.sv
design/tsm_front.sv
design/tsm_back.sv
design/tlb_shootdown_slot_mailbox_unit.sv
dv/tb_tlb_shootdown_slot_mailbox_unit.sv
